### rtl/acrs_pkg.sv
package acrs_pkg;

  localparam logic [2:0] ACT_CHECK    = 3'd0;
  localparam logic [2:0] ACT_ADD      = 3'd1;
  localparam logic [2:0] ACT_REMOVE   = 3'd2;
  localparam logic [2:0] ACT_CLEAR    = 3'd3;
  localparam logic [2:0] ACT_SNAPSHOT = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] range_start;
    logic [31:0] range_end;
  } in_item_t;

  typedef struct packed {
    logic       visible;
    logic       table_full;
    logic [6:0] range_count;
  } out_item_t;

  // Compare results of one table entry against a pair of operands.
  typedef struct packed {
    logic lo_lt_bl;
    logic lo_eq_bl;
    logic lo_lt_bh;
    logic lo_eq_bh;
    logic hi_lt_bl;
    logic hi_eq_bl;
    logic hi_lt_bh;
    logic hi_eq_bh;
  } cmp_flags_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHK_A,
    ST_CHK_B,
    ST_ADD1_A,
    ST_ADD1_B,
    ST_ADD2_A,
    ST_ADD2_B,
    ST_MRG_A,
    ST_MRG_B,
    ST_ADD3_A,
    ST_ADD3_B,
    ST_REM0,
    ST_SH1_A,
    ST_SH1_B,
    ST_SH2_A,
    ST_SH2_B,
    ST_REM_END,
    ST_CUT0,
    ST_CUT1_A,
    ST_CUT1_B,
    ST_CUT2_A,
    ST_CUT2_B,
    ST_CUT_FIX,
    ST_DROP_A,
    ST_DROP_B,
    ST_PUT0,
    ST_PUT_A,
    ST_PUT_B,
    ST_SNAP_A,
    ST_SNAP_B,
    ST_DONE
  } state_t;

endpackage

### rtl/angular_clip_range_set_unit.sv
// Keeps a sorted table of disjoint covered angle ranges and a saved copy of it (the
// silhouette), and runs one action per transaction: check, add with merge, remove with
// trim or split, clear, or snapshot. Every action but clear is worked by a small sequencer over
// the covered table RAM, whose single read port sets the pace: each entry visited takes
// a state that reads it and a state that compares it, and each entry shifted by an
// insert or delete takes a further read state and write state. An add walks the table
// up to three times and shifts entries for every range that it swallows; a remove runs
// one trim for each silhouette range that it steps past. The block takes no new
// transaction until the current one has placed its result in the output register;
// no clearing pass follows reset.
module angular_clip_range_set_unit #(
  parameter int MAX_RANGES = 64,
  parameter int ANGLE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  acrs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output acrs_pkg::out_item_t out_data
);

  localparam int AW = (ANGLE_BITS < 32) ? ANGLE_BITS : 32;
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int IW = $clog2(MAX_RANGES);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

  acrs_pkg::state_t state_r, state_nxt;
  acrs_pkg::state_t ret_r, ret_nxt;
  acrs_pkg::state_t cut_ret_r, cut_ret_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt, scnt_r, scnt_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, m_r, m_nxt, k_r, k_nxt, p_r, p_nxt;
  logic [AW-1:0] cs_r, cs_nxt, ce_r, ce_nxt, s_r, s_nxt, e_r, e_nxt;
  logic [AW-1:0] cur_lo_r, cur_lo_nxt, cur_hi_r, cur_hi_nxt;
  logic [AW-1:0] p_lo_r, p_lo_nxt, p_hi_r, p_hi_nxt;
  logic          vis_r, vis_nxt, full_r, full_nxt;
  logic          out_valid_r, out_valid_nxt;
  acrs_pkg::out_item_t out_data_r, out_data_nxt;

  logic            c_we;
  logic [IW-1:0]   c_waddr, c_raddr;
  logic [2*AW-1:0] c_wdata, c_rdata, s_rdata;
  logic            s_we;

  logic [AW-1:0] ent_lo, ent_hi, b_lo, b_hi;
  logic          use_shadow, use_merge;
  acrs_pkg::cmp_flags_t f;

  logic lo_ge_bl, lo_le_bl, lo_gt_bl, lo_le_bh, hi_ge_bl, hi_le_bl, hi_le_bh, hi_ge_bh;

  function automatic logic [IW-1:0] m_nxt_plus_one(input logic [CW-1:0] v);
    logic [CW-1:0] t;
    t = v + 1'b1;
    return t[IW-1:0];
  endfunction

  acrs_ram #(.WIDTH(2 * AW), .DEPTH(MAX_RANGES)) u_cover (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  acrs_ram #(.WIDTH(2 * AW), .DEPTH(MAX_RANGES)) u_shadow (
    .clk   (clk),
    .we    (s_we),
    .waddr (m_r[IW-1:0]),
    .wdata (c_rdata),
    .raddr (k_r[IW-1:0]),
    .rdata (s_rdata)
  );

  assign use_shadow = (state_r == acrs_pkg::ST_SH1_B) || (state_r == acrs_pkg::ST_SH2_B);
  assign use_merge  = (state_r == acrs_pkg::ST_MRG_B);
  assign ent_lo = use_shadow ? s_rdata[AW-1:0] : c_rdata[AW-1:0];
  assign ent_hi = use_shadow ? s_rdata[2*AW-1:AW] : c_rdata[2*AW-1:AW];
  assign b_lo   = use_shadow ? s_r : cs_r;
  assign b_hi   = use_merge ? cur_hi_r : (use_shadow ? e_r : ce_r);

  acrs_cmp #(.W(AW)) u_cmp (
    .a_lo  (ent_lo),
    .a_hi  (ent_hi),
    .b_lo  (b_lo),
    .b_hi  (b_hi),
    .flags (f)
  );

  assign lo_ge_bl = !f.lo_lt_bl;
  assign lo_le_bl = f.lo_lt_bl | f.lo_eq_bl;
  assign lo_gt_bl = !lo_le_bl;
  assign lo_le_bh = f.lo_lt_bh | f.lo_eq_bh;
  assign hi_ge_bl = !f.hi_lt_bl;
  assign hi_le_bl = f.hi_lt_bl | f.hi_eq_bl;
  assign hi_le_bh = f.hi_lt_bh | f.hi_eq_bh;
  assign hi_ge_bh = !f.hi_lt_bh;

  assign in_ready  = (state_r == acrs_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acrs_pkg::ST_IDLE;
      cnt_r       <= '0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      scnt_r      <= scnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r      <= ret_nxt;
    cut_ret_r  <= cut_ret_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    m_r        <= m_nxt;
    k_r        <= k_nxt;
    p_r        <= p_nxt;
    cs_r       <= cs_nxt;
    ce_r       <= ce_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    cur_lo_r   <= cur_lo_nxt;
    cur_hi_r   <= cur_hi_nxt;
    p_lo_r     <= p_lo_nxt;
    p_hi_r     <= p_hi_nxt;
    vis_r      <= vis_nxt;
    full_r     <= full_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cut_ret_nxt   = cut_ret_r;
    cnt_nxt       = cnt_r;
    scnt_nxt      = scnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    m_nxt         = m_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    cs_nxt        = cs_r;
    ce_nxt        = ce_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    cur_lo_nxt    = cur_lo_r;
    cur_hi_nxt    = cur_hi_r;
    p_lo_nxt      = p_lo_r;
    p_hi_nxt      = p_hi_r;
    vis_nxt       = vis_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    c_we          = 1'b0;
    c_waddr       = i_r[IW-1:0];
    c_wdata       = {cur_hi_r, cur_lo_r};
    c_raddr       = i_r[IW-1:0];
    s_we          = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      acrs_pkg::ST_IDLE: begin
        if (in_valid) begin
          cs_nxt   = in_data.range_start[AW-1:0];
          ce_nxt   = in_data.range_end[AW-1:0];
          s_nxt    = in_data.range_start[AW-1:0];
          e_nxt    = in_data.range_end[AW-1:0];
          vis_nxt  = 1'b0;
          full_nxt = 1'b0;
          i_nxt    = '0;
          case (in_data.action)
            acrs_pkg::ACT_CHECK: state_nxt = acrs_pkg::ST_CHK_A;
            acrs_pkg::ACT_ADD: begin
              if (cnt_r == '0) begin
                p_nxt     = '0;
                p_lo_nxt  = in_data.range_start[AW-1:0];
                p_hi_nxt  = in_data.range_end[AW-1:0];
                ret_nxt   = acrs_pkg::ST_DONE;
                state_nxt = acrs_pkg::ST_PUT0;
              end else begin
                state_nxt = acrs_pkg::ST_ADD1_A;
              end
            end
            acrs_pkg::ACT_REMOVE: state_nxt = acrs_pkg::ST_REM0;
            acrs_pkg::ACT_CLEAR: begin
              cnt_nxt   = '0;
              scnt_nxt  = '0;
              state_nxt = acrs_pkg::ST_DONE;
            end
            acrs_pkg::ACT_SNAPSHOT: begin
              m_nxt     = '0;
              state_nxt = acrs_pkg::ST_SNAP_A;
            end
            default: state_nxt = acrs_pkg::ST_DONE;
          endcase
        end
      end

      acrs_pkg::ST_CHK_A: begin
        if (i_r >= cnt_r) begin
          vis_nxt   = 1'b1;
          state_nxt = acrs_pkg::ST_DONE;
        end else begin
          state_nxt = acrs_pkg::ST_CHK_B;
        end
      end
      acrs_pkg::ST_CHK_B: begin
        if (!f.lo_lt_bh) begin
          // A zero end with the first range starting at zero reads as hidden.
          vis_nxt   = !((ce_r == '0) && (i_r == '0) && f.lo_eq_bh);
          state_nxt = acrs_pkg::ST_DONE;
        end else if (lo_le_bl && hi_ge_bh) begin
          vis_nxt   = 1'b0;
          state_nxt = acrs_pkg::ST_DONE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = acrs_pkg::ST_CHK_A;
        end
      end

      acrs_pkg::ST_ADD1_A: begin
        if (i_r >= cnt_r) begin
          i_nxt     = '0;
          state_nxt = acrs_pkg::ST_ADD2_A;
        end else begin
          state_nxt = acrs_pkg::ST_ADD1_B;
        end
      end
      acrs_pkg::ST_ADD1_B: begin
        if (!f.lo_lt_bh) begin
          i_nxt     = '0;
          state_nxt = acrs_pkg::ST_ADD2_A;
        end else if (lo_ge_bl && hi_le_bh) begin
          m_nxt     = i_r;
          ret_nxt   = acrs_pkg::ST_ADD1_A;
          state_nxt = acrs_pkg::ST_DROP_A;
        end else if (lo_le_bl && hi_ge_bh) begin
          state_nxt = acrs_pkg::ST_DONE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = acrs_pkg::ST_ADD1_A;
        end
      end

      acrs_pkg::ST_ADD2_A: begin
        if (i_r >= cnt_r) begin
          i_nxt     = '0;
          state_nxt = acrs_pkg::ST_ADD3_A;
        end else begin
          state_nxt = acrs_pkg::ST_ADD2_B;
        end
      end
      acrs_pkg::ST_ADD2_B: begin
        if (!lo_le_bh) begin
          i_nxt     = '0;
          state_nxt = acrs_pkg::ST_ADD3_A;
        end else if (hi_ge_bl) begin
          cur_lo_nxt = lo_gt_bl ? cs_r : ent_lo;
          cur_hi_nxt = f.hi_lt_bh ? ce_r : ent_hi;
          j_nxt      = i_r + 1'b1;
          state_nxt  = acrs_pkg::ST_MRG_A;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = acrs_pkg::ST_ADD2_A;
        end
      end

      // The merged entry is kept in registers and written back once its
      // neighbours have been folded in.
      acrs_pkg::ST_MRG_A: begin
        c_raddr = j_r[IW-1:0];
        if (j_r >= cnt_r) begin
          c_we      = 1'b1;
          state_nxt = acrs_pkg::ST_DONE;
        end else begin
          state_nxt = acrs_pkg::ST_MRG_B;
        end
      end
      acrs_pkg::ST_MRG_B: begin
        if (lo_le_bh) begin
          if (!hi_le_bh) begin
            cur_hi_nxt = ent_hi;
          end
          m_nxt     = j_r;
          ret_nxt   = acrs_pkg::ST_MRG_A;
          state_nxt = acrs_pkg::ST_DROP_A;
        end else begin
          c_we      = 1'b1;
          state_nxt = acrs_pkg::ST_DONE;
        end
      end

      acrs_pkg::ST_ADD3_A: begin
        if (i_r >= cnt_r) begin
          p_nxt     = i_r;
          p_lo_nxt  = cs_r;
          p_hi_nxt  = ce_r;
          ret_nxt   = acrs_pkg::ST_DONE;
          state_nxt = acrs_pkg::ST_PUT0;
        end else begin
          state_nxt = acrs_pkg::ST_ADD3_B;
        end
      end
      acrs_pkg::ST_ADD3_B: begin
        if (f.lo_lt_bh) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = acrs_pkg::ST_ADD3_A;
        end else begin
          p_nxt     = i_r;
          p_lo_nxt  = cs_r;
          p_hi_nxt  = ce_r;
          ret_nxt   = acrs_pkg::ST_DONE;
          state_nxt = acrs_pkg::ST_PUT0;
        end
      end

      acrs_pkg::ST_REM0: begin
        if (scnt_r == '0) begin
          cut_ret_nxt = acrs_pkg::ST_DONE;
          state_nxt   = acrs_pkg::ST_CUT0;
        end else begin
          k_nxt     = '0;
          state_nxt = acrs_pkg::ST_SH1_A;
        end
      end
      acrs_pkg::ST_SH1_A: begin
        state_nxt = (k_r >= scnt_r) ? acrs_pkg::ST_SH2_A : acrs_pkg::ST_SH1_B;
      end
      acrs_pkg::ST_SH1_B: begin
        if (hi_le_bl) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = acrs_pkg::ST_SH1_A;
        end else if (lo_le_bl) begin
          if (hi_ge_bh) begin
            state_nxt = acrs_pkg::ST_DONE;
          end else begin
            s_nxt     = ent_hi;
            k_nxt     = k_r + 1'b1;
            state_nxt = acrs_pkg::ST_SH2_A;
          end
        end else begin
          state_nxt = acrs_pkg::ST_SH2_A;
        end
      end
      acrs_pkg::ST_SH2_A: begin
        state_nxt = (k_r >= scnt_r) ? acrs_pkg::ST_REM_END : acrs_pkg::ST_SH2_B;
      end
      acrs_pkg::ST_SH2_B: begin
        if (f.lo_lt_bh) begin
          // Trim the gap up to this silhouette range, then resume after it.
          cs_nxt      = s_r;
          ce_nxt      = ent_lo;
          s_nxt       = ent_hi;
          k_nxt       = k_r + 1'b1;
          cut_ret_nxt = acrs_pkg::ST_SH2_A;
          state_nxt   = acrs_pkg::ST_CUT0;
        end else begin
          state_nxt = acrs_pkg::ST_REM_END;
        end
      end
      acrs_pkg::ST_REM_END: begin
        if (s_r >= e_r) begin
          state_nxt = acrs_pkg::ST_DONE;
        end else begin
          cs_nxt      = s_r;
          ce_nxt      = e_r;
          cut_ret_nxt = acrs_pkg::ST_DONE;
          state_nxt   = acrs_pkg::ST_CUT0;
        end
      end

      acrs_pkg::ST_CUT0: begin
        i_nxt     = '0;
        state_nxt = (cnt_r == '0) ? cut_ret_r : acrs_pkg::ST_CUT1_A;
      end
      acrs_pkg::ST_CUT1_A: begin
        if (i_r >= cnt_r) begin
          i_nxt     = '0;
          state_nxt = acrs_pkg::ST_CUT2_A;
        end else begin
          state_nxt = acrs_pkg::ST_CUT1_B;
        end
      end
      acrs_pkg::ST_CUT1_B: begin
        if (!f.lo_lt_bh) begin
          i_nxt     = '0;
          state_nxt = acrs_pkg::ST_CUT2_A;
        end else if (lo_ge_bl && hi_le_bh) begin
          m_nxt     = i_r;
          ret_nxt   = acrs_pkg::ST_CUT1_A;
          state_nxt = acrs_pkg::ST_DROP_A;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = acrs_pkg::ST_CUT1_A;
        end
      end
      acrs_pkg::ST_CUT2_A: begin
        state_nxt = (i_r >= cnt_r) ? cut_ret_r : acrs_pkg::ST_CUT2_B;
      end
      acrs_pkg::ST_CUT2_B: begin
        if (lo_ge_bl && lo_le_bh) begin
          c_we      = 1'b1;
          c_wdata   = {ent_hi, ce_r};
          state_nxt = cut_ret_r;
        end else if (hi_ge_bl && hi_le_bh) begin
          c_we      = 1'b1;
          c_wdata   = {cs_r, ent_lo};
          i_nxt     = i_r + 1'b1;
          state_nxt = acrs_pkg::ST_CUT2_A;
        end else if (f.lo_lt_bl && !hi_le_bh) begin
          if (cnt_r >= MAX_CNT) begin
            full_nxt  = 1'b1;
            state_nxt = cut_ret_r;
          end else begin
            cur_lo_nxt = ent_lo;
            cur_hi_nxt = cs_r;
            p_nxt      = i_r + 1'b1;
            p_lo_nxt   = ce_r;
            p_hi_nxt   = ent_hi;
            ret_nxt    = acrs_pkg::ST_CUT_FIX;
            state_nxt  = acrs_pkg::ST_PUT0;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = acrs_pkg::ST_CUT2_A;
        end
      end
      acrs_pkg::ST_CUT_FIX: begin
        c_we      = 1'b1;
        state_nxt = cut_ret_r;
      end

      // Delete entry m: move each later entry down by one.
      acrs_pkg::ST_DROP_A: begin
        c_raddr = m_nxt_plus_one(m_r);
        if (CW'(m_r + 1'b1) >= cnt_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = ret_r;
        end else begin
          state_nxt = acrs_pkg::ST_DROP_B;
        end
      end
      acrs_pkg::ST_DROP_B: begin
        c_we      = 1'b1;
        c_waddr   = m_r[IW-1:0];
        c_wdata   = c_rdata;
        m_nxt     = m_r + 1'b1;
        state_nxt = acrs_pkg::ST_DROP_A;
      end

      // Insert at p: move each entry from p up by one, starting at the top, then write.
      acrs_pkg::ST_PUT0: begin
        if (cnt_r >= MAX_CNT) begin
          full_nxt  = 1'b1;
          state_nxt = ret_r;
        end else begin
          m_nxt     = cnt_r;
          state_nxt = acrs_pkg::ST_PUT_A;
        end
      end
      acrs_pkg::ST_PUT_A: begin
        c_raddr = IW'(m_r - 1'b1);
        if (m_r <= p_r) begin
          c_we      = 1'b1;
          c_waddr   = p_r[IW-1:0];
          c_wdata   = {p_hi_r, p_lo_r};
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ret_r;
        end else begin
          state_nxt = acrs_pkg::ST_PUT_B;
        end
      end
      acrs_pkg::ST_PUT_B: begin
        c_we      = 1'b1;
        c_waddr   = m_r[IW-1:0];
        c_wdata   = c_rdata;
        m_nxt     = m_r - 1'b1;
        state_nxt = acrs_pkg::ST_PUT_A;
      end

      acrs_pkg::ST_SNAP_A: begin
        c_raddr = m_r[IW-1:0];
        if (m_r >= cnt_r) begin
          scnt_nxt  = cnt_r;
          state_nxt = acrs_pkg::ST_DONE;
        end else begin
          state_nxt = acrs_pkg::ST_SNAP_B;
        end
      end
      acrs_pkg::ST_SNAP_B: begin
        s_we      = 1'b1;
        m_nxt     = m_r + 1'b1;
        state_nxt = acrs_pkg::ST_SNAP_A;
      end

      acrs_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.visible     = vis_r;
          out_data_nxt.table_full  = full_r;
          out_data_nxt.range_count = 7'(cnt_r);
          state_nxt                = acrs_pkg::ST_IDLE;
        end
      end

      default: state_nxt = acrs_pkg::ST_IDLE;
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= MAX_CNT) && (scnt_r <= MAX_CNT))
    else $error("range count beyond table size");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != acrs_pkg::ST_IDLE) |-> !in_ready)
    else $error("ready raised while a transaction is in progress");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == acrs_pkg::ST_DONE))
    else $error("result appeared outside the completion step");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != acrs_pkg::ST_IDLE) && (state_r != acrs_pkg::ST_SNAP_A) |=>
    (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + 1'b1) ||
    (cnt_r == $past(cnt_r) - 1'b1))
    else $error("range count moved by more than one in a step");

endmodule

### rtl/acrs_ram.sv
module acrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/acrs_cmp.sv
module acrs_cmp #(
  parameter int W = 32
) (
  input  logic [W-1:0]           a_lo,
  input  logic [W-1:0]           a_hi,
  input  logic [W-1:0]           b_lo,
  input  logic [W-1:0]           b_hi,
  output acrs_pkg::cmp_flags_t   flags
);

  always_comb begin
    flags.lo_lt_bl = a_lo < b_lo;
    flags.lo_eq_bl = a_lo == b_lo;
    flags.lo_lt_bh = a_lo < b_hi;
    flags.lo_eq_bh = a_lo == b_hi;
    flags.hi_lt_bl = a_hi < b_lo;
    flags.hi_eq_bl = a_hi == b_lo;
    flags.hi_lt_bh = a_hi < b_hi;
    flags.hi_eq_bh = a_hi == b_hi;
  end

endmodule

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RANGES = 64;
  localparam int CYCLE_LIMIT = 100000000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  acrs_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  acrs_pkg::out_item_t out_data;

  angular_clip_range_set_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Predictor state: the covered table and the silhouette.
  logic [31:0] cov_lo[MAX_RANGES];
  logic [31:0] cov_hi[MAX_RANGES];
  int          cov_n;
  logic [31:0] sil_lo[MAX_RANGES];
  logic [31:0] sil_hi[MAX_RANGES];
  int          sil_n;
  bit          full_seen;

  acrs_pkg::out_item_t expected_results[$];
  int                  error_count = 0;
  int                  cycle_count = 0;
  int                  out_wait = 0;

  task automatic drop_at(input int i);
    if (i >= cov_n) return;
    for (int k = i; k + 1 < cov_n; k++) begin
      cov_lo[k] = cov_lo[k+1];
      cov_hi[k] = cov_hi[k+1];
    end
    cov_n--;
  endtask

  task automatic insert_at(input int p, input logic [31:0] lo, input logic [31:0] hi);
    if (cov_n >= MAX_RANGES) begin
      full_seen = 1'b1;
      return;
    end
    if (p > cov_n) p = cov_n;
    for (int k = cov_n; k > p; k--) begin
      cov_lo[k] = cov_lo[k-1];
      cov_hi[k] = cov_hi[k-1];
    end
    cov_lo[p] = lo;
    cov_hi[p] = hi;
    cov_n++;
  endtask

  function automatic bit is_visible(input logic [31:0] s, input logic [31:0] e);
    if (e == 0 && cov_n > 0 && cov_lo[0] == 0) return 1'b0;
    for (int i = 0; i < cov_n && cov_lo[i] < e; i++)
      if (s >= cov_lo[i] && e <= cov_hi[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic merge_range(input logic [31:0] s, input logic [31:0] e);
    int i;
    int j;
    if (cov_n == 0) begin
      insert_at(0, s, e);
      return;
    end
    i = 0;
    while (i < cov_n && cov_lo[i] < e) begin
      if (cov_lo[i] >= s && cov_hi[i] <= e) drop_at(i);
      else if (cov_lo[i] <= s && cov_hi[i] >= e) return;
      else i++;
    end
    for (i = 0; i < cov_n && cov_lo[i] <= e; i++) begin
      if (cov_hi[i] >= s) begin
        if (cov_lo[i] > s) cov_lo[i] = s;
        if (cov_hi[i] < e) cov_hi[i] = e;
        j = i + 1;
        while (j < cov_n && cov_lo[j] <= cov_hi[i]) begin
          if (cov_hi[j] > cov_hi[i]) cov_hi[i] = cov_hi[j];
          drop_at(j);
        end
        return;
      end
    end
    i = 0;
    while (i < cov_n && cov_lo[i] < e) i++;
    insert_at(i, s, e);
  endtask

  task automatic trim_range(input logic [31:0] s, input logic [31:0] e);
    int i;
    if (cov_n == 0) return;
    i = 0;
    while (i < cov_n && cov_lo[i] < e) begin
      if (cov_lo[i] >= s && cov_hi[i] <= e) drop_at(i);
      else i++;
    end
    for (i = 0; i < cov_n; i++) begin
      if (cov_lo[i] >= s && cov_lo[i] <= e) begin
        cov_lo[i] = e;
        break;
      end else if (cov_hi[i] >= s && cov_hi[i] <= e) begin
        cov_hi[i] = s;
      end else if (cov_lo[i] < s && cov_hi[i] > e) begin
        if (cov_n >= MAX_RANGES) begin
          full_seen = 1'b1;
          break;
        end
        insert_at(i + 1, e, cov_hi[i]);
        cov_hi[i] = s;
        break;
      end
    end
  endtask

  // Removal skips whatever the silhouette covers.
  task automatic uncover_range(input logic [31:0] s, input logic [31:0] e);
    int k;
    if (sil_n > 0) begin
      k = 0;
      while (k < sil_n && sil_hi[k] <= s) k++;
      if (k < sil_n && sil_lo[k] <= s) begin
        if (sil_hi[k] >= e) return;
        s = sil_hi[k];
        k++;
      end
      while (k < sil_n && sil_lo[k] < e) begin
        trim_range(s, sil_lo[k]);
        s = sil_hi[k];
        k++;
      end
      if (s >= e) return;
    end
    trim_range(s, e);
  endtask

  task automatic predict_action(input acrs_pkg::in_item_t it);
    acrs_pkg::out_item_t r;
    r = '0;
    full_seen = 1'b0;
    case (it.action)
      acrs_pkg::ACT_CHECK:  r.visible = is_visible(it.range_start, it.range_end);
      acrs_pkg::ACT_ADD:    merge_range(it.range_start, it.range_end);
      acrs_pkg::ACT_REMOVE: uncover_range(it.range_start, it.range_end);
      acrs_pkg::ACT_CLEAR: begin
        cov_n = 0;
        sil_n = 0;
      end
      acrs_pkg::ACT_SNAPSHOT: begin
        sil_lo = cov_lo;
        sil_hi = cov_hi;
        sil_n = cov_n;
      end
      default: ;
    endcase
    r.table_full = full_seen;
    r.range_count = cov_n[6:0];
    expected_results.push_back(r);
  endtask

  // Valid is dropped only when a gap follows, so it never gets two updates in one step.
  task automatic send_item(input logic [2:0] act, input logic [31:0] s, input logic [31:0] e);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{action: act, range_start: s, range_end: e};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_action('{action: act, range_start: s, range_end: e});
  endtask

  // Result checking and back-pressure: each result waits a drawn number of cycles.
  always @(posedge clk) begin
    acrs_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction %p", out_data);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.visible !== want.visible) begin
          $error("visible: expected %0d, got %0d", want.visible, out_data.visible);
          error_count++;
        end
        if (out_data.table_full !== want.table_full) begin
          $error("table_full: expected %0d, got %0d", want.table_full, out_data.table_full);
          error_count++;
        end
        if (out_data.range_count !== want.range_count) begin
          $error("range_count: expected %0d, got %0d", want.range_count,
                 out_data.range_count);
          error_count++;
        end
      end
      out_wait = $urandom_range(0, 12);
    end else if (out_valid && out_wait > 0) begin
      out_wait--;
    end
    out_ready <= (out_wait == 0);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL angular_clip_range_set_unit");
      $finish;
    end
  end

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  task automatic test_directed();
    send_item(acrs_pkg::ACT_CHECK, 32'd0, 32'd0);
    send_item(acrs_pkg::ACT_REMOVE, 32'd5, 32'd10);
    send_item(acrs_pkg::ACT_ADD, 32'd0, 32'd100);
    send_item(acrs_pkg::ACT_CHECK, 32'd7, 32'd0);
    send_item(acrs_pkg::ACT_CHECK, 32'd10, 32'd50);
    send_item(acrs_pkg::ACT_CHECK, 32'd50, 32'd150);
    send_item(acrs_pkg::ACT_ADD, 32'd200, 32'd300);
    send_item(acrs_pkg::ACT_ADD, 32'd100, 32'd200);
    send_item(acrs_pkg::ACT_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_item(acrs_pkg::ACT_SNAPSHOT, 32'd0, 32'd0);
    send_item(acrs_pkg::ACT_REMOVE, 32'd50, 32'd60);
    send_item(acrs_pkg::ACT_CLEAR, 32'd0, 32'd0);
    send_item(acrs_pkg::ACT_ADD, 32'd500, 32'd20);
    send_item(acrs_pkg::ACT_ADD, 32'd30, 32'd40);
    send_item(acrs_pkg::ACT_REMOVE, 32'd32, 32'd32);
    send_item(acrs_pkg::ACT_REMOVE, 32'd0, 32'hFFFF_FFFF);
    send_item(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(3'd6, 32'd1, 32'd2);
    send_item(3'd7, 32'hAAAA_5555, 32'h5555_AAAA);
    send_item(acrs_pkg::ACT_CLEAR, 32'd0, 32'd0);
  endtask

  // Fill the table to its limit, then provoke a dropped add and a dropped split.
  task automatic test_full_table();
    for (int i = 0; i < MAX_RANGES; i++) send_item(acrs_pkg::ACT_ADD, 10 * i, 10 * i + 4);
    send_item(acrs_pkg::ACT_ADD, 32'd1000, 32'd1002);
    send_item(acrs_pkg::ACT_REMOVE, 32'd1, 32'd2);
    send_item(acrs_pkg::ACT_REMOVE, 32'd2, 32'd3);
    send_item(acrs_pkg::ACT_ADD, 32'd5, 32'd6);
    send_item(acrs_pkg::ACT_SNAPSHOT, 32'd0, 32'd0);
    send_item(acrs_pkg::ACT_REMOVE, 32'd0, 32'd400);
    send_item(acrs_pkg::ACT_CLEAR, 32'd0, 32'd0);
  endtask

  task automatic test_random(input int n);
    logic [31:0] s;
    logic [31:0] e;
    int          act;
    for (int i = 0; i < n; i++) begin
      s = pick_angle();
      e = ($urandom_range(0, 7) == 0) ? pick_angle() : s + $urandom_range(0, 60);
      act = $urandom_range(0, 99);
      if (act < 30)      send_item(acrs_pkg::ACT_CHECK, s, e);
      else if (act < 65) send_item(acrs_pkg::ACT_ADD, s, e);
      else if (act < 88) send_item(acrs_pkg::ACT_REMOVE, s, e);
      else if (act < 94) send_item(acrs_pkg::ACT_SNAPSHOT, s, e);
      else if (act < 97) send_item(acrs_pkg::ACT_CLEAR, s, e);
      else               send_item(3'($urandom_range(5, 7)), $urandom, $urandom);
    end
  endtask

  initial begin
    cov_n = 0;
    sil_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(900);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASS angular_clip_range_set_unit");
    end else begin
      $display("FAIL angular_clip_range_set_unit");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/acrs_pkg.sv
rtl/acrs_ram.sv
rtl/acrs_cmp.sv
rtl/angular_clip_range_set_unit.sv
tb/tb_top.sv
